FILE: rtl/dflp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dflp_pkg;

    // Line terminator and the separator value after reset
    localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0] SEP_RESET     = 8'h20;

    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    // Argument slots after the sender and command fields
    localparam int         ARG_SLOTS     = 8;
    localparam logic [4:0] ARG_COUNT_MAX = 5'd8;

    typedef logic [15:0] t_value;

    // Conversion phase of the field being read
    typedef logic [1:0] t_phase;
    localparam t_phase PH_SKIP   = 2'd0;
    localparam t_phase PH_SIGN   = 2'd1;
    localparam t_phase PH_DIGITS = 2'd2;
    localparam t_phase PH_DONE   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/decimal_field_line_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// -------   ---------  -----------------  ----------------------------------------------
// rx byte   in         i_valid / o_stall  i_rx_byte
// line      out        o_valid / i_stall  o_sender_id, o_command_id, o_arg_count,
//                                         o_arg_zero .. o_arg_seven, o_overflow
// separator cfg        i_sep_we           i_sep_wdata
//
// One word enters every cycle while o_stall is low. A word waits in the input register,
// then the field conversion (one multiply-by-ten and add) updates the line state and, on
// newline, loads the result register, from which the line shows on o_valid.
// Synchronous active-low reset clears the line state, the field store and both valid flags.
// A stalled result holds; only a newline waits behind it, other bytes keep flowing.

module decimal_field_line_parser_unit #(
    parameter int MAX_FIELDS      = 10,
    parameter int MAX_FIELD_CHARS = 9
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_sep_we,
    input  wire  [7:0]            i_sep_wdata,

    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [7:0]            i_rx_byte,

    output logic                  o_valid,
    input  wire                   i_stall,
    output logic signed [15:0]    o_sender_id,
    output logic signed [15:0]    o_command_id,
    output logic signed [4:0]     o_arg_count,
    output logic signed [15:0]    o_arg_zero,
    output logic signed [15:0]    o_arg_one,
    output logic signed [15:0]    o_arg_two,
    output logic signed [15:0]    o_arg_three,
    output logic signed [15:0]    o_arg_four,
    output logic signed [15:0]    o_arg_five,
    output logic signed [15:0]    o_arg_six,
    output logic signed [15:0]    o_arg_seven,
    output logic                  o_overflow
);

    import dflp_pkg::*;

    // Field index counts up to MAX_FIELDS itself
    localparam int FW = $clog2(MAX_FIELDS + 1);
    // Character count up to MAX_FIELD_CHARS itself
    localparam int CW = $clog2(MAX_FIELD_CHARS + 1);
    localparam logic [FW-1:0] FIELDS_LIM = FW'(MAX_FIELDS);
    localparam logic [CW-1:0] CHARS_LIM  = CW'(MAX_FIELD_CHARS);

    // Separator register
    logic [7:0]     r_sep;

    // Input register
    logic           r_in_vld;
    logic [7:0]     r_in_byte;

    // Line state
    t_value         r_acc,   n_acc;
    logic           r_neg,   n_neg;
    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_cc,    n_cc;
    logic [FW-1:0]  r_idx,   n_idx;
    logic           r_ovf,   n_ovf;
    t_value         r_fld [MAX_FIELDS];
    t_value         n_fld [MAX_FIELDS];

    // Result register
    logic           r_out_vld;
    t_value         r_sender, r_command;
    logic [4:0]     r_count;
    t_value         r_args [ARG_SLOTS];
    logic           r_out_ovf;

    logic           w_is_nl;
    logic           w_is_sep;
    logic           w_adv;
    logic           w_load;
    logic           w_is_digit;
    logic           w_is_space;
    logic [3:0]     w_digit;
    t_value         w_cur;
    t_value         w_acc10;
    logic           w_room;
    logic [FW-1:0]  w_fields;
    logic [4:0]     w_cnt_raw;
    logic           w_too_many;
    t_value         w_args [ARG_SLOTS];

    // ---------------------------------------------------------------------
    // Handshake: a newline waits only while the result register is full and
    // stalled; every other byte advances at once.
    // ---------------------------------------------------------------------
    assign w_is_nl  = (r_in_byte == NEWLINE_BYTE);
    // Newline wins over a separator of the same value
    assign w_is_sep = !w_is_nl && (r_in_byte == r_sep);
    assign w_adv    = r_in_vld && (!w_is_nl || !r_out_vld || !i_stall);
    assign w_load   = w_adv && w_is_nl;
    assign o_stall  = r_in_vld && !w_adv;

    // ---------------------------------------------------------------------
    // Character classes and the value of the open field
    // ---------------------------------------------------------------------
    assign w_is_digit = (r_in_byte inside {[CHAR_ZERO:CHAR_NINE]});
    assign w_is_space = (r_in_byte inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE});
    assign w_digit    = 4'(r_in_byte - CHAR_ZERO);
    assign w_acc10    = (r_acc << 3) + (r_acc << 1) + t_value'(w_digit);
    assign w_cur      = r_neg ? (16'd0 - r_acc) : r_acc;
    assign w_room     = (r_idx < FIELDS_LIM);

    // ---------------------------------------------------------------------
    // Next line state for the byte in the input register
    // ---------------------------------------------------------------------
    always_comb begin
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_phase = r_phase;
        n_cc    = r_cc;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        for (int k = 0; k < MAX_FIELDS; k++) begin
            n_fld[k] = r_fld[k];
        end

        if (w_is_nl || w_is_sep) begin
            // Close the field: store it if a slot is left, else flag the drop
            for (int k = 0; k < MAX_FIELDS; k++) begin
                if (w_room && (FW'(k) == r_idx)) begin
                    n_fld[k] = w_cur;
                end
            end
            if (w_room) begin
                n_idx = r_idx + FW'(1);
            end else begin
                n_ovf = 1'b1;
            end
            n_acc   = '0;
            n_neg   = 1'b0;
            n_phase = PH_SKIP;
            n_cc    = '0;
        end else if (r_cc >= CHARS_LIM) begin
            // Drop characters past the field limit
            n_ovf = 1'b1;
        end else begin
            n_cc = r_cc + CW'(1);
            case (r_phase)
                PH_SKIP: begin
                    if (w_is_space) begin
                        n_phase = PH_SKIP;
                    end else if (r_in_byte == CHAR_PLUS || r_in_byte == CHAR_MINUS) begin
                        n_neg   = (r_in_byte == CHAR_MINUS);
                        n_phase = PH_SIGN;
                    end else if (w_is_digit) begin
                        n_acc   = t_value'(w_digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (w_is_digit) begin
                        n_acc   = w_acc10;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Result assembly on newline. Unwritten store slots are zero, so absent
    // fields read as zero without further guarding.
    // ---------------------------------------------------------------------
    assign w_fields   = n_idx;
    assign w_cnt_raw  = 5'(w_fields) - 5'd2;
    assign w_too_many = (5'(w_fields) > (ARG_COUNT_MAX + 5'd2));

    for (genvar g = 0; g < ARG_SLOTS; g++) begin : g_arg
        if (g + 2 < MAX_FIELDS) begin : g_have
            assign w_args[g] = n_fld[g + 2];
        end else begin : g_none
            assign w_args[g] = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_sep_we) begin
            r_sep <= i_sep_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    // Hold the byte while it waits behind a stalled result
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_phase <= PH_SKIP;
            r_cc    <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < MAX_FIELDS; k++) begin
                r_fld[k] <= '0;
            end
        end else if (w_load) begin
            // End of line: clear everything for the next one
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_phase <= PH_SKIP;
            r_cc    <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < MAX_FIELDS; k++) begin
                r_fld[k] <= '0;
            end
        end else if (w_adv) begin
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_phase <= n_phase;
            r_cc    <= n_cc;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            for (int k = 0; k < MAX_FIELDS; k++) begin
                r_fld[k] <= n_fld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sender  <= n_fld[0];
            r_command <= n_fld[1];
            r_count   <= w_too_many ? ARG_COUNT_MAX : w_cnt_raw;
            r_out_ovf <= n_ovf || w_too_many;
            for (int k = 0; k < ARG_SLOTS; k++) begin
                r_args[k] <= w_args[k];
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sender_id  = r_sender;
    assign o_command_id = r_command;
    assign o_arg_count  = r_count;
    assign o_arg_zero   = r_args[0];
    assign o_arg_one    = r_args[1];
    assign o_arg_two    = r_args[2];
    assign o_arg_three  = r_args[3];
    assign o_arg_four   = r_args[4];
    assign o_arg_five   = r_args[5];
    assign o_arg_six    = r_args[6];
    assign o_arg_seven  = r_args[7];
    assign o_overflow   = r_out_ovf;

endmodule

`default_nettype wire
